// File: hdl/bsf_pkg.sv
// shared constants, types and control/status structs for the fraction bucket sorter
package bsf_pkg;

   localparam int MAX_ITEMS  = 64;
   localparam int VALUE_BITS = 16;
   localparam int IDX_W      = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
   localparam int DATA_W     = ((VALUE_BITS + 7) / 8) * 8;
   localparam int PROD_W     = VALUE_BITS + CNT_W;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
   } link_type;

   localparam int LINK_W = $bits(link_type);

   typedef enum logic [1:0] {
      RD_CUR,
      RD_HEAD,
      RD_LINK
   } rd_sel_type;

   typedef enum logic [1:0] {
      CUR_HEAD,
      CUR_LNK,
      CUR_RDLINK
   } cur_sel_type;

   typedef enum logic [1:0] {
      LW_END,
      LW_HEAD,
      LW_LNK,
      LW_NODE
   } lw_sel_type;

   typedef struct packed {
      logic        req_ready;
      logic        take_req;
      logic        head_rsel_req;
      rd_sel_type  rd_sel;
      logic        cur_load;
      cur_sel_type cur_sel;
      logic        lnk_load;
      logic        link_we;
      lw_sel_type  link_wsel;
      logic        link_at_cur;
      logic        head_we;
      logic        count_inc;
      logic        load_out;
      logic        scan_inc;
      logic        clear;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic last;
      logic hv_bucket;
      logic hv_scan;
      logic val_ge;
      logic link_valid;
      logic lnk_valid;
      logic scan_last;
      logic out_busy;
   } sts_type;

endpackage

// File: hdl/bsf_ram.sv
// generic single-write, single-read memory with registered read data
module bsf_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/bsf_datapath.sv
// node store, bucket heads, counters and output register of the sorter
module bsf_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  bsf_pkg::cmd_type          cmd,
   output bsf_pkg::sts_type          sts,
   input  logic [bsf_pkg::DATA_W-1:0] req_tdata,
   input  logic                      req_tlast,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [bsf_pkg::DATA_W-1:0] rsp_tdata,
   output logic                      rsp_tlast,
   output logic                      rsp_tuser
);
   import bsf_pkg::*;

   logic [VALUE_BITS-1:0] req_value;
   logic [PROD_W-1:0]     req_prod;
   logic [IDX_W-1:0]      req_bucket;

   logic [VALUE_BITS-1:0] v_ff;
   logic                  last_ff;
   logic [IDX_W-1:0]      b_ff;
   logic [IDX_W-1:0]      cur_ff, cur_in;
   link_type              lnk_ff;
   logic [CNT_W-1:0]      count_ff, k_ff;
   logic                  ovf_ff;
   logic [MAX_ITEMS-1:0]  hv_ff;
   logic [IDX_W-1:0]      scan_ff;

   logic                  out_valid_ff;
   logic [VALUE_BITS-1:0] out_value_ff;
   logic                  out_last_ff;
   logic                  out_drop_ff;

   logic [IDX_W-1:0]      node_idx;
   logic [IDX_W-1:0]      rd_addr;
   logic [IDX_W-1:0]      head_raddr;
   logic [IDX_W-1:0]      head_rdata;
   logic [VALUE_BITS-1:0] val_rdata;
   logic [LINK_W-1:0]     link_rdata_raw;
   link_type              link_rdata;
   link_type              link_wdata;
   logic [IDX_W-1:0]      link_waddr;
   logic                  val_we;

   assign req_value  = req_tdata[VALUE_BITS-1:0];
   assign req_prod   = PROD_W'(req_value) * PROD_W'(MAX_ITEMS);
   assign req_bucket = IDX_W'(req_prod >> VALUE_BITS);
   assign node_idx   = count_ff[IDX_W-1:0];
   assign link_rdata = link_type'(link_rdata_raw);
   assign val_we     = cmd.take_req && !sts.full;

   always_comb begin
      case (cmd.rd_sel)
         RD_HEAD: rd_addr = head_rdata;
         RD_LINK: rd_addr = link_rdata.idx;
         default: rd_addr = cur_ff;
      endcase
   end

   always_comb begin
      case (cmd.cur_sel)
         CUR_HEAD:   cur_in = head_rdata;
         CUR_LNK:    cur_in = lnk_ff.idx;
         CUR_RDLINK: cur_in = link_rdata.idx;
         default:    cur_in = cur_ff;
      endcase
   end

   always_comb begin
      case (cmd.link_wsel)
         LW_HEAD: link_wdata = '{valid: 1'b1, idx: cur_ff};
         LW_LNK:  link_wdata = lnk_ff;
         LW_NODE: link_wdata = '{valid: 1'b1, idx: node_idx};
         default: link_wdata = '{valid: 1'b0, idx: '0};
      endcase
   end

   assign link_waddr = cmd.link_at_cur ? cur_ff : node_idx;
   assign head_raddr = cmd.head_rsel_req ? req_bucket : scan_ff;

   bsf_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_values (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (node_idx),
      .wr_data (req_value),
      .rd_addr (rd_addr),
      .rd_data (val_rdata)
   );

   bsf_ram #(.WIDTH(LINK_W), .DEPTH(MAX_ITEMS)) u_links (
      .clock   (clock),
      .wr_en   (cmd.link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (rd_addr),
      .rd_data (link_rdata_raw)
   );

   bsf_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ITEMS)) u_heads (
      .clock   (clock),
      .wr_en   (cmd.head_we),
      .wr_addr (b_ff),
      .wr_data (node_idx),
      .rd_addr (head_raddr),
      .rd_data (head_rdata)
   );

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         v_ff    <= req_value;
         last_ff <= req_tlast;
         b_ff    <= req_bucket;
      end
      if (cmd.cur_load) begin
         cur_ff <= cur_in;
      end
      if (cmd.lnk_load) begin
         lnk_ff <= link_rdata;
      end
      if (cmd.load_out) begin
         out_value_ff <= val_rdata;
         out_last_ff  <= ((k_ff + CNT_W'(1)) == count_ff);
         out_drop_ff  <= ovf_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         count_ff <= '0;
         k_ff     <= '0;
         ovf_ff   <= 1'b0;
         hv_ff    <= '0;
         scan_ff  <= '0;
      end else begin
         if (cmd.take_req && sts.full) begin
            ovf_ff <= 1'b1;
         end
         if (cmd.count_inc) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.head_we) begin
            hv_ff[b_ff] <= 1'b1;
         end
         if (cmd.scan_inc) begin
            scan_ff <= scan_ff + IDX_W'(1);
         end
         if (cmd.load_out) begin
            k_ff <= k_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign sts.full       = (count_ff == CNT_W'(MAX_ITEMS));
   assign sts.last       = last_ff;
   assign sts.hv_bucket  = hv_ff[b_ff];
   assign sts.hv_scan    = hv_ff[scan_ff];
   assign sts.val_ge     = (val_rdata >= v_ff);
   assign sts.link_valid = link_rdata.valid;
   assign sts.lnk_valid  = lnk_ff.valid;
   assign sts.scan_last  = (scan_ff == IDX_W'(MAX_ITEMS - 1));
   assign sts.out_busy   = out_valid_ff && !rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = DATA_W'(out_value_ff);
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_drop_ff;

endmodule

// File: hdl/bsf_ctrl.sv
// sequencer for list insertion and the sorted readout
module bsf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tlast,
   input  bsf_pkg::sts_type sts,
   output bsf_pkg::cmd_type cmd
);
   import bsf_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HEAD,
      ST_FIRST,
      ST_NEXT,
      ST_LINK2,
      ST_DONE,
      ST_SCAN,
      ST_EHEAD,
      ST_EOUT,
      ST_CLEAR
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd           = '0;
      cmd.rd_sel    = RD_CUR;
      cmd.cur_sel   = CUR_HEAD;
      cmd.link_wsel = LW_END;
      state_in      = state_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.req_ready     = 1'b1;
            cmd.head_rsel_req = 1'b1;
            if (req_tvalid) begin
               cmd.take_req = 1'b1;
               if (!sts.full) begin
                  state_in = ST_HEAD;
               end else if (req_tlast) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_HEAD: begin
            if (!sts.hv_bucket) begin
               cmd.link_we   = 1'b1;
               cmd.link_wsel = LW_END;
               cmd.head_we   = 1'b1;
               state_in      = ST_DONE;
            end else begin
               cmd.rd_sel   = RD_HEAD;
               cmd.cur_load = 1'b1;
               cmd.cur_sel  = CUR_HEAD;
               state_in     = ST_FIRST;
            end
         end
         ST_FIRST: begin
            if (sts.val_ge) begin
               cmd.link_we   = 1'b1;
               cmd.link_wsel = LW_HEAD;
               cmd.head_we   = 1'b1;
               state_in      = ST_DONE;
            end else begin
               cmd.lnk_load = 1'b1;
               cmd.rd_sel   = RD_LINK;
               state_in     = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (!sts.lnk_valid || sts.val_ge) begin
               cmd.link_we   = 1'b1;
               cmd.link_wsel = LW_LNK;
               state_in      = ST_LINK2;
            end else begin
               cmd.cur_load = 1'b1;
               cmd.cur_sel  = CUR_LNK;
               cmd.lnk_load = 1'b1;
               cmd.rd_sel   = RD_LINK;
            end
         end
         ST_LINK2: begin
            cmd.link_we     = 1'b1;
            cmd.link_wsel   = LW_NODE;
            cmd.link_at_cur = 1'b1;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            cmd.count_inc = 1'b1;
            state_in      = sts.last ? ST_SCAN : ST_IDLE;
         end
         ST_SCAN: begin
            if (sts.hv_scan) begin
               state_in = ST_EHEAD;
            end else if (sts.scan_last) begin
               state_in = ST_CLEAR;
            end else begin
               cmd.scan_inc = 1'b1;
            end
         end
         ST_EHEAD: begin
            cmd.rd_sel   = RD_HEAD;
            cmd.cur_load = 1'b1;
            cmd.cur_sel  = CUR_HEAD;
            state_in     = ST_EOUT;
         end
         ST_EOUT: begin
            if (!sts.out_busy) begin
               cmd.load_out = 1'b1;
               if (sts.link_valid) begin
                  cmd.rd_sel   = RD_LINK;
                  cmd.cur_load = 1'b1;
                  cmd.cur_sel  = CUR_RDLINK;
               end else if (sts.scan_last) begin
                  state_in = ST_CLEAR;
               end else begin
                  cmd.scan_inc = 1'b1;
                  state_in     = ST_SCAN;
               end
            end
         end
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/bucket_sort_fraction.sv
// top level of the fraction bucket sorter
// Sorts a batch of unsigned 0.16 fractions. Each request is placed into bucket
// floor(value*MAX_ITEMS/2^16) and linked into that bucket's ascending list in a
// node store of MAX_ITEMS entries; requests past that capacity are dropped and
// flagged in rsp_tuser for the whole batch. A request that lands in an empty
// bucket passes through the head check straight to the done step; one that goes
// ahead of the bucket head adds the first-node compare; otherwise the list walk
// follows, one node per cycle through the node store's read port, then the
// second link write. The request with tlast set then starts the readout, which
// scans the buckets in order, reads the head of each non-empty bucket, emits
// its results while rsp_tready allows, and clears the batch at the end. Bucket
// occupancy lives in flip-flops, so no clearing pass over the memories is
// needed after reset or between batches.
module bucket_sort_fraction (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [bsf_pkg::DATA_W-1:0] req_tdata,  // sample_value
   input  logic                       req_tlast,  // batch_end
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [bsf_pkg::DATA_W-1:0] rsp_tdata,  // sorted_value
   output logic                       rsp_tlast,  // run_end
   output logic                       rsp_tuser   // items_dropped
);
   import bsf_pkg::*;

   cmd_type cmd;
   sts_type sts;

   bsf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .sts        (sts),
      .cmd        (cmd)
   );

   bsf_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   assign req_tready = cmd.req_ready;

endmodule

// File: hdl/bsf_checker.sv
// port-level checks for the fraction bucket sorter
module bsf_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic [bsf_pkg::DATA_W-1:0] req_tdata,
   input logic                       req_tlast,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [bsf_pkg::DATA_W-1:0] rsp_tdata,
   input logic                       rsp_tlast,
   input logic                       rsp_tuser
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // waiting request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata)
         && $stable(req_tlast))
      else $error("waiting request changed");

   // no new request while a run is still being read out
   a_no_req_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken during readout");

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind bucket_sort_fraction bsf_checker u_bsf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
